FILE: src/strf_pkg.sv
// ----------------------------------------------------------------------------
// strf_pkg: shared definitions of the transmitter register file
// Widths, register offsets, operation and alias codes, reset values, masks
// and the alias write helper used by the channels and the register file.
// ----------------------------------------------------------------------------
package strf_pkg;

    // FIFO geometry (valid range of FIFO_DEPTH: 4 to 16, even).
    localparam int FIFO_DEPTH = 8;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    // Field widths of the bus channels.
    localparam int OP_W   = 2;
    localparam int IDX_W  = 9;
    localparam int MOD_W  = 2;
    localparam int DATA_W = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    // Address alias codes.
    localparam logic [MOD_W-1:0] MOD_PLAIN  = 2'd0;
    localparam logic [MOD_W-1:0] MOD_SET    = 2'd1;
    localparam logic [MOD_W-1:0] MOD_CLEAR  = 2'd2;
    localparam logic [MOD_W-1:0] MOD_TOGGLE = 2'd3;

    // Register offsets.
    localparam logic [IDX_W-1:0] IDX_CTRL      = 9'd0;
    localparam logic [IDX_W-1:0] IDX_STAT      = 9'd1;
    localparam logic [IDX_W-1:0] IDX_FRAMECTRL = 9'd2;
    localparam logic [IDX_W-1:0] IDX_SRR       = 9'd3;
    localparam logic [IDX_W-1:0] IDX_DEBUG     = 9'd4;
    localparam logic [IDX_W-1:0] IDX_DATA      = 9'd5;
    localparam logic [IDX_W-1:0] IDX_VERSION   = 9'd6;

    // CTRL bit positions.
    localparam int CB_RUN  = 0;
    localparam int CB_ERR  = 1;
    localparam int CB_OVF  = 2;
    localparam int CB_UNF  = 3;
    localparam int CB_WLEN = 4;
    localparam int CB_GATE = 30;
    localparam int CB_SRST = 31;

    // Masks and reset values.
    localparam logic [DATA_W-1:0] CTRL_MASK     = 32'hc01f003f;
    localparam logic [DATA_W-1:0] CTRL_INIT     = 32'hc0000020;
    localparam logic [DATA_W-1:0] FCTL_MASK     = 32'h000377ff;
    localparam logic [DATA_W-1:0] FCTL_INIT     = 32'h00020000;
    localparam logic [DATA_W-1:0] SRR_MASK      = 32'h700fffff;
    localparam logic [DATA_W-1:0] SRR_INIT      = 32'h10000000;
    localparam logic [DATA_W-1:0] VERSION_VALUE = 32'h01010000;
    localparam logic [DATA_W-1:0] STAT_BASE     = 32'h80000000;

    // Plain, set, clear or toggle write through a writable mask.
    function automatic logic [DATA_W-1:0] alias_write(
        input logic [DATA_W-1:0] old_v,
        input logic [DATA_W-1:0] new_v,
        input logic [DATA_W-1:0] mask,
        input logic [MOD_W-1:0]  md
    );
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] m;
        w = old_v & mask;
        m = new_v & mask;
        unique case (md)
            MOD_PLAIN:  w = m;
            MOD_SET:    w = w | m;
            MOD_CLEAR:  w = w & ~m;
            MOD_TOGGLE: w = w ^ m;
        endcase
        return (old_v & ~mask) | w;
    endfunction

endpackage

FILE: src/strf_cmd_if.sv
// ----------------------------------------------------------------------------
// strf_cmd_if: bus command channel
// Carries one bus read, bus write or frame tick per beat.
// ----------------------------------------------------------------------------
interface strf_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [strf_pkg::OP_W-1:0]     operation;
    logic [strf_pkg::IDX_W-1:0]    reg_index;
    logic [strf_pkg::MOD_W-1:0]    modifier;
    logic [strf_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output operation, output reg_index,
                    output modifier, output write_data, input ready);
    modport sink   (input valid, input operation, input reg_index,
                    input modifier, input write_data, output ready);
endinterface

FILE: src/strf_rsp_if.sv
// ----------------------------------------------------------------------------
// strf_rsp_if: result channel
// Carries read data, interrupt and DMA levels and the popped frame per beat.
// ----------------------------------------------------------------------------
interface strf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [strf_pkg::DATA_W-1:0]   read_data;
    logic                          irq_level;
    logic                          dma_request;
    logic                          frame_valid;
    logic [strf_pkg::DATA_W-1:0]   frame_word_first;
    logic [strf_pkg::DATA_W-1:0]   frame_word_second;

    modport source (output valid, output read_data, output irq_level,
                    output dma_request, output frame_valid,
                    output frame_word_first, output frame_word_second,
                    input ready);
    modport sink   (input valid, input read_data, input irq_level,
                    input dma_request, input frame_valid,
                    input frame_word_first, input frame_word_second,
                    output ready);
endinterface

FILE: src/spdif_tx_register_fifo.sv
// ----------------------------------------------------------------------------
// spdif_tx_register_fifo: register file and transmit FIFO
// Bus reads, aliased writes and frame ticks against CTRL, FRAMECTRL, SRR and
// a shifting sample FIFO, one result beat per command beat.
// ----------------------------------------------------------------------------
// Each command beat yields exactly one result beat, in order. The command
// lands in an input register, the whole register and FIFO update is done in
// one pass of logic, and the result lands in an output register. Throughput
// is one command per cycle as long as results are taken; while the output
// register is held, one more command waits in the input register and then
// cmd.ready drops. The FIFO is a shift line of FIFO_DEPTH words read only at
// its head, so a tick pops a frame in the same pass.
module spdif_tx_register_fifo (
    input  logic   clk,
    input  logic   rst_n,
    strf_cmd_if.sink   cmd,
    strf_rsp_if.source rsp
);
    import strf_pkg::*;

    // Input stage.
    logic                in_valid_reg;
    logic [OP_W-1:0]     op_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [MOD_W-1:0]    mod_reg;
    logic [DATA_W-1:0]   data_reg;

    // Architectural state.
    logic [DATA_W-1:0]   ctl_reg, ctl_next;
    logic [DATA_W-1:0]   fctl_reg, fctl_next;
    logic [DATA_W-1:0]   srr_reg, srr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                conv_reg, conv_next;
    logic                tend_reg, tend_next;
    logic                dtog_reg, dtog_next;
    logic [DATA_W-1:0]   fifo_reg [FIFO_DEPTH];
    logic [DATA_W-1:0]   fifo_next [FIFO_DEPTH];

    // Output stage.
    logic                out_valid_reg;
    logic [DATA_W-1:0]   rd_reg;
    logic                irq_reg;
    logic                fv_reg;
    logic [DATA_W-1:0]   w0_reg;
    logic [DATA_W-1:0]   w1_reg;

    // Per-command results of the update pass.
    logic [DATA_W-1:0]   rd_c;
    logic                fv_c;
    logic [DATA_W-1:0]   w0_c;
    logic [DATA_W-1:0]   w1_c;
    logic [DATA_W-1:0]   ctl_w;
    logic [FILL_W-1:0]   cap;
    logic [FILL_W-1:0]   cap_w;
    logic [FILL_W-1:0]   frame_n;
    logic                advance;

    // The input register moves on when the output register is free.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;

    // Capacity follows the word length bit.
    assign cap = ctl_reg[CB_WLEN] ? FILL_W'(FIFO_DEPTH) : FILL_W'(FIFO_DEPTH / 2);

    // Register and FIFO update for the command in the input register.
    always_comb
    begin
        ctl_next  = ctl_reg;
        fctl_next = fctl_reg;
        srr_next  = srr_reg;
        fill_next = fill_reg;
        conv_next = conv_reg;
        tend_next = tend_reg;
        dtog_next = dtog_reg;
        fifo_next = fifo_reg;
        rd_c      = '0;
        fv_c      = 1'b0;
        w0_c      = '0;
        w1_c      = '0;
        ctl_w     = alias_write(ctl_reg, data_reg, CTRL_MASK, mod_reg);
        cap_w     = ctl_w[CB_WLEN] ? FILL_W'(FIFO_DEPTH) : FILL_W'(FIFO_DEPTH / 2);
        frame_n   = ctl_reg[CB_WLEN] ? FILL_W'(1) : FILL_W'(2);

        // Status bits only clear through the clear alias.
        if (mod_reg == MOD_PLAIN || mod_reg == MOD_TOGGLE)
        begin
            ctl_w[CB_OVF] = ctl_reg[CB_OVF];
            ctl_w[CB_UNF] = ctl_reg[CB_UNF];
        end

        unique case (op_reg)
            OP_READ:
            begin
                if (mod_reg == MOD_PLAIN)
                begin
                    unique case (idx_reg)
                        IDX_CTRL:      rd_c = ctl_reg;
                        IDX_STAT:      rd_c = STAT_BASE | {31'd0, tend_reg};
                        IDX_FRAMECTRL: rd_c = fctl_reg;
                        IDX_SRR:       rd_c = srr_reg;
                        IDX_DEBUG:     rd_c = {30'd0, dtog_reg, fill_reg < cap};
                        IDX_VERSION:   rd_c = VERSION_VALUE;
                        default:       rd_c = '0;
                    endcase
                end
            end
            OP_WRITE:
            begin
                unique case (idx_reg)
                    IDX_CTRL:
                    begin
                        if (ctl_w[CB_SRST])
                        begin
                            // Soft reset restores every reset value.
                            ctl_next  = CTRL_INIT;
                            fctl_next = FCTL_INIT;
                            srr_next  = SRR_INIT;
                            fill_next = '0;
                            conv_next = 1'b0;
                            tend_next = 1'b0;
                            dtog_next = 1'b0;
                        end
                        else
                        begin
                            ctl_next = ctl_w;
                            if (ctl_w[CB_RUN] != ctl_reg[CB_RUN])
                            begin
                                if (ctl_w[CB_RUN])
                                begin
                                    tend_next = 1'b0;
                                    if (fill_reg == cap_w)
                                        conv_next = 1'b1;
                                end
                                else if (fill_reg == '0 && conv_reg)
                                begin
                                    tend_next = 1'b1;
                                    conv_next = 1'b0;
                                end
                            end
                        end
                    end
                    IDX_FRAMECTRL:
                        fctl_next = alias_write(fctl_reg, data_reg, FCTL_MASK, mod_reg);
                    IDX_SRR:
                        srr_next = alias_write(srr_reg, data_reg, SRR_MASK, mod_reg);
                    IDX_DATA:
                    begin
                        // Push one word unless gated or in soft reset; a full FIFO flags overflow.
                        if (!(ctl_reg[CB_SRST] || ctl_reg[CB_GATE]))
                        begin
                            if (fill_reg >= cap)
                                ctl_next[CB_OVF] = 1'b1;
                            else
                            begin
                                for (int i = 0; i < FIFO_DEPTH; i++)
                                begin
                                    if (fill_reg == FILL_W'(i))
                                        fifo_next[i] = data_reg;
                                end
                                fill_next = fill_reg + FILL_W'(1);
                                if (ctl_reg[CB_RUN] && fill_next == cap)
                                begin
                                    conv_next = 1'b1;
                                    tend_next = 1'b0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            OP_TICK:
            begin
                // Pop one frame, or flag underflow when too few words are held.
                if (ctl_reg[CB_RUN] && !ctl_reg[CB_SRST] && !ctl_reg[CB_GATE] && conv_reg)
                begin
                    if (fill_reg >= frame_n)
                    begin
                        w0_c      = fifo_reg[0];
                        if (!ctl_reg[CB_WLEN])
                            w1_c = fifo_reg[1];
                        fv_c      = 1'b1;
                        fill_next = fill_reg - frame_n;
                        dtog_next = !dtog_reg;
                        if (ctl_reg[CB_WLEN])
                        begin
                            for (int i = 0; i < FIFO_DEPTH - 1; i++)
                                fifo_next[i] = fifo_reg[i + 1];
                        end
                        else
                        begin
                            for (int i = 0; i < FIFO_DEPTH - 2; i++)
                                fifo_next[i] = fifo_reg[i + 2];
                        end
                    end
                    else
                        ctl_next[CB_UNF] = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cmd.ready)
            in_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg   <= cmd.operation;
            idx_reg  <= cmd.reg_index;
            mod_reg  <= cmd.modifier;
            data_reg <= cmd.write_data;
        end
    end

    // Control and status state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= CTRL_INIT;
            fctl_reg <= FCTL_INIT;
            srr_reg  <= SRR_INIT;
            fill_reg <= '0;
            conv_reg <= 1'b0;
            tend_reg <= 1'b0;
            dtog_reg <= 1'b0;
        end
        else if (advance)
        begin
            ctl_reg  <= ctl_next;
            fctl_reg <= fctl_next;
            srr_reg  <= srr_next;
            fill_reg <= fill_next;
            conv_reg <= conv_next;
            tend_reg <= tend_next;
            dtog_reg <= dtog_next;
        end
    end

    // Sample FIFO words; entries at or above the fill count are never read.
    always_ff @(posedge clk)
    begin
        if (advance)
            fifo_reg <= fifo_next;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_reg  <= rd_c;
            irq_reg <= ctl_next[CB_ERR] && (ctl_next[CB_OVF] || ctl_next[CB_UNF]);
            fv_reg  <= fv_c;
            w0_reg  <= w0_c;
            w1_reg  <= w1_c;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.read_data         = rd_reg;
    assign rsp.irq_level         = irq_reg;
    assign rsp.dma_request       = dtog_reg;
    assign rsp.frame_valid       = fv_reg;
    assign rsp.frame_word_first  = w0_reg;
    assign rsp.frame_word_second = w1_reg;

`ifndef SYNTHESIS
    // A popped frame always flips the DMA request line.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && fv_c |=> dtog_reg != $past(dtog_reg))
        else $error("DMA request did not toggle on a popped frame");

    // The fill count never passes the FIFO depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(FIFO_DEPTH))
        else $error("FIFO fill count beyond depth");

    // Commands are only held back while both stages are occupied and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> in_valid_reg && out_valid_reg && !rsp.ready)
        else $error("command stalled without a stalled result");
`endif

endmodule

FILE: tb/strf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strf_checker: result checker of the transmitter register file
// Watches the command and result channels and keeps its own copy of the
// registers and the sample FIFO. It works out the result of every accepted
// command beat and compares each result beat, field by field, with the oldest
// result still owed.
// ----------------------------------------------------------------------------
module strf_checker (
    input  logic clk,
    input  logic rst_n,
    strf_cmd_if  cmd,
    strf_rsp_if  rsp,
    output int   mismatches,
    output int   pending_results
);
    import strf_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_level;
        logic              dma_request;
        logic              frame_valid;
        logic [DATA_W-1:0] word_first;
        logic [DATA_W-1:0] word_second;
    } result_t;

    // Shadow copy of the block's state.
    logic [DATA_W-1:0] ctrl_q;
    logic [DATA_W-1:0] fctl_q;
    logic [DATA_W-1:0] srr_q;
    logic [DATA_W-1:0] fifo_words [FIFO_DEPTH];
    int                fill;
    logic              converting;
    logic              xfer_done;
    logic              dma_tgl;

    result_t owed_results [$];
    result_t head_result;
    int      fault_count = 0;
    int      result_index = 0;

    // Values that hold after reset and after a soft reset.
    function automatic void restore_defaults();
        ctrl_q     = CTRL_INIT;
        fctl_q     = FCTL_INIT;
        srr_q      = SRR_INIT;
        fill       = 0;
        converting = 1'b0;
        xfer_done  = 1'b0;
        dma_tgl    = 1'b0;
        for (int i = 0; i < FIFO_DEPTH; i++)
            fifo_words[i] = '0;
    endfunction

    // A frame is one word in 32-bit mode, two words otherwise.
    function automatic int frame_len();
        return ctrl_q[CB_WLEN] ? 1 : 2;
    endfunction

    function automatic int fifo_room();
        return ctrl_q[CB_WLEN] ? FIFO_DEPTH : FIFO_DEPTH / 2;
    endfunction

    // Only bits inside the mask change; the alias picks how.
    function automatic logic [DATA_W-1:0] masked_update(
        input logic [DATA_W-1:0] old_v,
        input logic [DATA_W-1:0] new_v,
        input logic [DATA_W-1:0] mask,
        input logic [MOD_W-1:0]  md
    );
        logic [DATA_W-1:0] kept;
        logic [DATA_W-1:0] req;
        kept = old_v & mask;
        req  = new_v & mask;
        case (md)
            MOD_SET:    kept = kept | req;
            MOD_CLEAR:  kept = kept & ~req;
            MOD_TOGGLE: kept = kept ^ req;
            default:    kept = req;
        endcase
        return (old_v & ~mask) | kept;
    endfunction

    // Applies one command to the shadow state and returns its result.
    function automatic result_t regfile_step(
        input logic [OP_W-1:0]   op,
        input logic [IDX_W-1:0]  idx,
        input logic [MOD_W-1:0]  md,
        input logic [DATA_W-1:0] val
    );
        result_t           res;
        logic [DATA_W-1:0] ctrl_before;
        int                n;
        int                i;
        res = '0;
        case (op)
            OP_READ:
            begin
                // Alias addresses always read as zero.
                if (md == MOD_PLAIN)
                begin
                    case (idx)
                        IDX_CTRL:      res.read_data = ctrl_q;
                        IDX_STAT:      res.read_data = STAT_BASE |
                                                       {{(DATA_W-1){1'b0}}, xfer_done};
                        IDX_FRAMECTRL: res.read_data = fctl_q;
                        IDX_SRR:       res.read_data = srr_q;
                        IDX_DEBUG:     res.read_data = {{(DATA_W-2){1'b0}}, dma_tgl,
                                                        (fill < fifo_room())};
                        IDX_VERSION:   res.read_data = VERSION_VALUE;
                        default:       res.read_data = '0;
                    endcase
                end
            end
            OP_WRITE:
            begin
                case (idx)
                    IDX_CTRL:
                    begin
                        ctrl_before = ctrl_q;
                        ctrl_q = masked_update(ctrl_before, val, CTRL_MASK, md);
                        // Status bits move only through the set and clear aliases.
                        if (md == MOD_PLAIN || md == MOD_TOGGLE)
                        begin
                            ctrl_q[CB_OVF] = ctrl_before[CB_OVF];
                            ctrl_q[CB_UNF] = ctrl_before[CB_UNF];
                        end
                        if (ctrl_q[CB_SRST])
                        begin
                            restore_defaults();
                        end
                        else if (ctrl_q[CB_RUN] != ctrl_before[CB_RUN])
                        begin
                            if (ctrl_q[CB_RUN])
                            begin
                                xfer_done = 1'b0;
                                if (fill == fifo_room())
                                    converting = 1'b1;
                            end
                            else if (fill == 0 && converting)
                            begin
                                xfer_done  = 1'b1;
                                converting = 1'b0;
                            end
                        end
                    end
                    IDX_FRAMECTRL: fctl_q = masked_update(fctl_q, val, FCTL_MASK, md);
                    IDX_SRR:       srr_q  = masked_update(srr_q, val, SRR_MASK, md);
                    IDX_DATA:
                    begin
                        // Pushes are dropped while gated or in soft reset.
                        if (!ctrl_q[CB_SRST] && !ctrl_q[CB_GATE])
                        begin
                            if (fill >= fifo_room())
                            begin
                                ctrl_q[CB_OVF] = 1'b1;
                            end
                            else
                            begin
                                fifo_words[fill] = val;
                                fill++;
                                if (ctrl_q[CB_RUN] && fill == fifo_room())
                                begin
                                    converting = 1'b1;
                                    xfer_done  = 1'b0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            OP_TICK:
            begin
                if (ctrl_q[CB_RUN] && !ctrl_q[CB_SRST] && !ctrl_q[CB_GATE] && converting)
                begin
                    n = frame_len();
                    if (fill >= n)
                    begin
                        res.frame_valid = 1'b1;
                        res.word_first  = fifo_words[0];
                        if (n == 2)
                            res.word_second = fifo_words[1];
                        fill = fill - n;
                        for (i = 0; i < fill && i + n < FIFO_DEPTH; i++)
                            fifo_words[i] = fifo_words[i + n];
                        dma_tgl = !dma_tgl;
                    end
                    else
                    begin
                        ctrl_q[CB_UNF] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.irq_level   = ctrl_q[CB_ERR] && (ctrl_q[CB_OVF] || ctrl_q[CB_UNF]);
        res.dma_request = dma_tgl;
        return res;
    endfunction

    function automatic void compare_field(
        input string             name,
        input logic [DATA_W-1:0] got,
        input logic [DATA_W-1:0] want
    );
        if (got !== want)
        begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
                $display("result %0d: %s expected %h, got %h", result_index, name, want, got);
        end
    endfunction

    // Predict on every command beat, compare on every result beat.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            restore_defaults();
            owed_results.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                owed_results.push_back(regfile_step(cmd.operation, cmd.reg_index,
                                                    cmd.modifier, cmd.write_data));
            if (rsp.valid && rsp.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("result %0d: beat arrived with no command outstanding",
                                 result_index);
                end
                else
                begin
                    head_result = owed_results.pop_front();
                    compare_field("read_data", rsp.read_data, head_result.read_data);
                    compare_field("irq_level", rsp.irq_level, head_result.irq_level);
                    compare_field("dma_request", rsp.dma_request, head_result.dma_request);
                    compare_field("frame_valid", rsp.frame_valid, head_result.frame_valid);
                    compare_field("frame_word_first", rsp.frame_word_first,
                                  head_result.word_first);
                    compare_field("frame_word_second", rsp.frame_word_second,
                                  head_result.word_second);
                end
                result_index++;
            end
        end
        mismatches      <= fault_count;
        pending_results <= owed_results.size();
    end

endmodule

FILE: tb/tb_spdif_tx_register_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spdif_tx_register_fifo: testbench of the transmitter register file
// Drives a directed opening and then a weighted random mix of register
// accesses, sample pushes and frame ticks, with random gaps and stalls on
// both channels and one long hold-off of the result channel. A checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_spdif_tx_register_fifo;
    import strf_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_BEATS = 1200;
    localparam int HOLD_AFTER   = 300;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;

    // Operation code the block does not define.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [DATA_W-1:0] BIT_RUN  = DATA_W'(1) << CB_RUN;
    localparam logic [DATA_W-1:0] BIT_ERR  = DATA_W'(1) << CB_ERR;
    localparam logic [DATA_W-1:0] BIT_OVF  = DATA_W'(1) << CB_OVF;
    localparam logic [DATA_W-1:0] BIT_UNF  = DATA_W'(1) << CB_UNF;
    localparam logic [DATA_W-1:0] BIT_SRST = DATA_W'(1) << CB_SRST;

    logic clk;
    logic rst_n;
    logic calm = 1'b0;
    logic held_off;
    int   mismatches;
    int   pending_results;
    int   results_seen = 0;
    int   beats_sent = 0;

    strf_cmd_if cmd_ch ();
    strf_rsp_if rsp_ch ();

    spdif_tx_register_fifo dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    strf_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_ch),
        .rsp             (rsp_ch),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one command beat, waits for it to be taken, then idles a while.
    task automatic drive_command(
        input logic [OP_W-1:0]   op,
        input logic [IDX_W-1:0]  idx,
        input logic [MOD_W-1:0]  md,
        input logic [DATA_W-1:0] data
    );
        int gap;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.operation  <= op;
        cmd_ch.reg_index  <= idx;
        cmd_ch.modifier   <= md;
        cmd_ch.write_data <= data;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        beats_sent++;
        calm <= ((beats_sent / 150) % 4) == 3;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Count result beats taken.
    always @(posedge clk)
        if (rsp_ch.valid && rsp_ch.ready)
            results_seen <= results_seen + 1;

    // Result side: random stalls and one long hold-off.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        held_off = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && results_seen >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // End the run when neither channel moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  idx;
        logic [MOD_W-1:0]  md;
        logic [DATA_W-1:0] data;
        int                roll;
        rst_n             = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.operation  = OP_READ;
        cmd_ch.reg_index  = IDX_CTRL;
        cmd_ch.modifier   = MOD_PLAIN;
        cmd_ch.write_data = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of every register and an unmapped index.
        drive_command(OP_READ, IDX_CTRL, MOD_PLAIN, '0);
        drive_command(OP_READ, IDX_STAT, MOD_PLAIN, '0);
        drive_command(OP_READ, IDX_FRAMECTRL, MOD_PLAIN, '0);
        drive_command(OP_READ, IDX_SRR, MOD_PLAIN, '0);
        drive_command(OP_READ, IDX_DEBUG, MOD_PLAIN, '0);
        drive_command(OP_READ, IDX_DATA, MOD_PLAIN, '0);
        drive_command(OP_READ, IDX_VERSION, MOD_PLAIN, '0);
        drive_command(OP_READ, IDX_VERSION + 1'b1, MOD_PLAIN, '0);

        // Alias read, top index, unused operation, push while gated.
        drive_command(OP_READ, IDX_CTRL, MOD_SET, '0);
        drive_command(OP_READ, '1, MOD_PLAIN, '0);
        drive_command(OP_UNUSED, '1, MOD_TOGGLE, '1);
        drive_command(OP_WRITE, IDX_DATA, MOD_PLAIN, 32'hdead_beef);

        // Writes to a read-only register are ignored; SRR keeps the masked ones.
        drive_command(OP_WRITE, IDX_VERSION, MOD_TOGGLE, '1);
        drive_command(OP_WRITE, IDX_SRR, MOD_PLAIN, '1);

        // Ungate in two-word mode, fill the FIFO and push once too many.
        drive_command(OP_WRITE, IDX_CTRL, MOD_PLAIN, BIT_ERR);
        drive_command(OP_WRITE, IDX_DATA, MOD_PLAIN, 32'hffff_ffff);
        drive_command(OP_WRITE, IDX_DATA, MOD_SET, 32'h0000_0000);
        drive_command(OP_WRITE, IDX_DATA, MOD_CLEAR, 32'ha5a5_a5a5);
        drive_command(OP_WRITE, IDX_DATA, MOD_TOGGLE, 32'h5a5a_5a5a);
        drive_command(OP_WRITE, IDX_DATA, MOD_PLAIN, 32'h1234_5678);

        // Start a run on a full FIFO, drain it and underflow once.
        drive_command(OP_WRITE, IDX_CTRL, MOD_SET, BIT_RUN);
        drive_command(OP_TICK, IDX_CTRL, MOD_PLAIN, '0);
        drive_command(OP_TICK, IDX_CTRL, MOD_PLAIN, '0);
        drive_command(OP_TICK, IDX_CTRL, MOD_PLAIN, '0);

        // Clear status, stop on an empty FIFO, then soft reset.
        drive_command(OP_WRITE, IDX_CTRL, MOD_CLEAR, BIT_OVF | BIT_UNF);
        drive_command(OP_WRITE, IDX_CTRL, MOD_PLAIN, BIT_ERR);
        drive_command(OP_READ, IDX_STAT, MOD_PLAIN, '0);
        drive_command(OP_WRITE, IDX_CTRL, MOD_PLAIN, BIT_SRST);

        // Weighted random mix; most beats keep the FIFO moving.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            roll = $urandom_range(0, 99);
            op   = OP_WRITE;
            idx  = IDX_DATA;
            md   = MOD_W'($urandom_range(0, 3));
            data = $urandom();
            if (roll < 8)
            begin
                // Control write, mostly plain and mostly ungated.
                idx = IDX_CTRL;
                if ($urandom_range(0, 2) != 0)
                    md = MOD_PLAIN;
                if ($urandom_range(0, 11) != 0)
                begin
                    data[CB_SRST] = 1'b0;
                    data[CB_GATE] = 1'b0;
                end
                data[CB_RUN] = ($urandom_range(0, 3) != 0);
            end
            else if (roll < 40)
            begin
                idx = IDX_DATA;
            end
            else if (roll < 66)
            begin
                op  = OP_TICK;
                idx = IDX_W'($urandom_range(int'(IDX_CTRL), int'(IDX_VERSION) + 1));
            end
            else if (roll < 86)
            begin
                op  = OP_READ;
                idx = IDX_W'($urandom_range(int'(IDX_CTRL), int'(IDX_VERSION) + 1));
                if ($urandom_range(0, 4) != 0)
                    md = MOD_PLAIN;
            end
            else if (roll < 93)
            begin
                idx = ($urandom_range(0, 1) != 0) ? IDX_FRAMECTRL : IDX_SRR;
            end
            else
            begin
                op  = OP_W'($urandom_range(0, 3));
                idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
            end
            drive_command(op, idx, md, data);
        end

        // Let every owed result arrive, then allow for stray beats.
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
